@@ src/gas_pkg.sv @@
// Shared types, constants and helpers of the grid path search block.
package gas_pkg;

  localparam int CoordW   = 4;
  localparam int CellAw   = 3 * CoordW;
  localparam int NCells   = 1 << CellAw;
  localparam int CntW     = CellAw + 1;
  localparam int SizeW    = 5;
  localparam int DimSize  = 1 << CoordW;
  localparam int CostFrac = 8;
  localparam int CostW    = 24;
  localparam int PrioW    = 28;
  localparam int OrdW     = 17;
  localparam int DirW     = 5;
  localparam int OctW     = 14;
  localparam int HeurW    = 18;
  localparam int TieW     = 16;
  localparam int ClrW     = 16;
  localparam int StepW    = 12;

  localparam int Sqrt2Q20 = 1482910;
  localparam int Sqrt3Q20 = 1816187;
  localparam int CostOneI = 1 << CostFrac;
  localparam int CostSq2I = (Sqrt2Q20 + (1 << (19 - CostFrac))) >> (20 - CostFrac);
  localparam int CostSq3I = (Sqrt3Q20 + (1 << (19 - CostFrac))) >> (20 - CostFrac);
  localparam logic [CostW-1:0] COST_ONE = CostW'(CostOneI);
  localparam logic [CostW-1:0] COST_SQ2 = CostW'(CostSq2I);
  localparam logic [CostW-1:0] COST_SQ3 = CostW'(CostSq3I);

  localparam logic [DirW-1:0] NO_PARENT = DirW'(13);
  localparam logic [DirW-1:0] DIR_MAX   = DirW'(26);

  localparam logic [1:0] MARK_FREE   = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FOUND  = 2'd1;
  localparam logic [1:0] ST_NOPATH = 2'd2;
  localparam logic [1:0] ST_BEYOND = 2'd3;

  localparam logic [2:0] CFG_SIZE_X = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z = 3'd2;
  localparam logic [2:0] CFG_TIE    = 3'd3;
  localparam logic [2:0] CFG_CLRMIN = 3'd4;

  localparam logic [CntW-1:0] EXP_MAX = CntW'(NCells);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } coord_t;

  typedef struct packed {
    logic [1:0]       mark;
    logic [CostW-1:0] cost;
    logic [PrioW-1:0] prio;
    logic [DirW-1:0]  parent;
    logic [OrdW-1:0]  order;
  } node_t;

  localparam int NodeW = $bits(node_t);

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) r = SizeW'(1);
    else if (v > SizeW'(DimSize)) r = SizeW'(DimSize);
    else r = v;
    return r;
  endfunction

  function automatic logic [CoordW-1:0] clamp_idx(input logic [CoordW-1:0] v,
                                                  input logic [SizeW-1:0] size);
    logic [SizeW-1:0] m;
    m = size - SizeW'(1);
    return ({1'b0, v} >= size) ? m[CoordW-1:0] : v;
  endfunction

  // Split a parent code into per-axis offsets, each 0..2 (offset + 1).
  function automatic logic [5:0] dir_split(input logic [DirW-1:0] d);
    logic [1:0]      ax;
    logic [1:0]      ay;
    logic [DirW-1:0] rem;
    if (d >= DirW'(18)) ax = 2'd2;
    else if (d >= DirW'(9)) ax = 2'd1;
    else ax = 2'd0;
    rem = d - DirW'(ax) * DirW'(9);
    if (rem >= DirW'(6)) ay = 2'd2;
    else if (rem >= DirW'(3)) ay = 2'd1;
    else ay = 2'd0;
    rem = rem - DirW'(ay) * DirW'(3);
    return {ax, ay, rem[1:0]};
  endfunction

endpackage

@@ src/grid_a_star_path_search.sv @@
// Top level: request handling, A* sequencer, path walk and result register.
//
// A load request, an unused request or a path read goes straight from idle to
// the result stage. A search first clears the marks, then per expansion scans
// all 4096 node entries and visits the 26 neighbours one after another; the
// node memory's single read port keeps those visits serial. The path walk reads
// each path cell's parent from the node memory and writes the cell to the path
// memory. After reset the clearance memory is cleared, during which no request is taken.
module grid_a_star_path_search import gas_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic [CoordW-1:0]   cell_x_i,
  input  logic [CoordW-1:0]   cell_y_i,
  input  logic [CoordW-1:0]   cell_z_i,
  input  logic signed [ClrW-1:0] clearance_i,
  input  logic [CoordW-1:0]   start_x_i,
  input  logic [CoordW-1:0]   start_y_i,
  input  logic [CoordW-1:0]   start_z_i,
  input  logic [CoordW-1:0]   goal_x_i,
  input  logic [CoordW-1:0]   goal_y_i,
  input  logic [CoordW-1:0]   goal_z_i,
  input  logic [StepW-1:0]    step_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [CntW-1:0]     path_length_o,
  output logic [CoordW-1:0]   path_x_o,
  output logic [CoordW-1:0]   path_y_o,
  output logic [CoordW-1:0]   path_z_o,
  output logic [CntW-1:0]     expansions_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_SWR, S_SCAN, S_SEL, S_NB, S_NB_CHK, S_NB_HW,
    S_NB_WR, S_PRD, S_PWR, S_DONE
  } state_e;

  state_e state_q;

  logic [SizeW-1:0] size_x_q, size_y_q, size_z_q, lx, ly, lz;
  logic [TieW-1:0]  tie_q;
  logic signed [ClrW-1:0] cmin_q;

  coord_t           goal_q, hc_q, pc_q, ncrd;
  node_t            best_q, node_rd, node_wdata;
  logic [CellAw-1:0] best_idx_q, n_q, scan_a_q;
  logic             any_q, scan_v_q, rd_path_q;
  logic [CntW-1:0]  sc_q, iter_q, last_exp_q, path_cnt_q, k_q, iter_n, k_n;
  logic [1:0]       nbx_q, nby_q, nbz_q, nbx_n, nby_n, nbz_n;
  logic [CostW-1:0] t_q, step_cost, t_new;
  logic [OrdW-1:0]  ins_q;
  logic [1:0]       st_q;
  logic [HeurW-1:0] heur;
  logic [5:0]       nx6, ny6, nz6;
  logic             nb_oob, nb_center, nb_last, nb_skip, scan_take;
  logic [1:0]       nonzero;
  logic [5:0]       pdir;
  logic [4:0]       px5, py5, pz5;
  logic [CntW-1:0]  raddr13;

  logic             node_we, node_re, clr_we, clr_re, path_we, path_re;
  logic [CellAw-1:0] node_waddr, node_raddr, clr_waddr, clr_raddr, path_waddr,
                     path_raddr;
  logic [NodeW-1:0] node_rdata;
  logic [ClrW-1:0]  clr_wdata, clr_rdata;
  logic [CellAw-1:0] path_wdata, path_rdata;
  logic             acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i && !in_stall_o;
  assign lx = eff_size(size_x_q);
  assign ly = eff_size(size_y_q);
  assign lz = eff_size(size_z_q);
  assign node_rd = node_t'(node_rdata);

  gas_ram #(.Width(NodeW), .Aw(CellAw)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(node_rdata)
  );

  gas_ram #(.Width(ClrW), .Aw(CellAw)) u_clr_ram (
    .clk_i, .we_i(clr_we), .waddr_i(clr_waddr), .wdata_i(clr_wdata),
    .re_i(clr_re), .raddr_i(clr_raddr), .rdata_o(clr_rdata)
  );

  gas_ram #(.Width(CellAw), .Aw(CellAw)) u_path_ram (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .re_i(path_re), .raddr_i(path_raddr), .rdata_o(path_rdata)
  );

  gas_heur u_heur (
    .clk_i, .cell_i(hc_q), .goal_i(goal_q), .tie_i(tie_q), .heur_o(heur)
  );

  // Neighbour walk and per-state datapath terms
  always_comb begin
    nbx_n = nbx_q; nby_n = nby_q; nbz_n = nbz_q;
    if (nbz_q == 2'd2) begin
      nbz_n = 2'd0;
      if (nby_q == 2'd2) begin
        nby_n = 2'd0;
        nbx_n = nbx_q + 2'd1;
      end else begin
        nby_n = nby_q + 2'd1;
      end
    end else begin
      nbz_n = nbz_q + 2'd1;
    end
    nb_last   = (nbx_q == 2'd2) && (nby_q == 2'd2) && (nbz_q == 2'd2);
    nb_center = (nbx_q == 2'd1) && (nby_q == 2'd1) && (nbz_q == 2'd1);
    nx6 = {2'b0, best_idx_q[11:8]} + {4'b0, nbx_q} - 6'd1;
    ny6 = {2'b0, best_idx_q[7:4]} + {4'b0, nby_q} - 6'd1;
    nz6 = {2'b0, best_idx_q[3:0]} + {4'b0, nbz_q} - 6'd1;
    nb_oob = (nx6 >= {1'b0, lx}) || (ny6 >= {1'b0, ly}) || (nz6 >= {1'b0, lz});
    ncrd = '{x: nx6[3:0], y: ny6[3:0], z: nz6[3:0]};
    nonzero = 2'((nbx_q != 2'd1)) + 2'((nby_q != 2'd1)) + 2'((nbz_q != 2'd1));
    unique case (nonzero)
      2'd1:    step_cost = COST_ONE;
      2'd2:    step_cost = COST_SQ2;
      default: step_cost = COST_SQ3;
    endcase
    t_new = best_q.cost + step_cost;
    nb_skip = ($signed(clr_rdata) < cmin_q) || (node_rd.mark == MARK_CLOSED)
           || ((node_rd.mark == MARK_OPEN) && (t_new > node_rd.cost));
    scan_take = scan_v_q && (node_rd.mark == MARK_OPEN) &&
                (!any_q || (node_rd.prio < best_q.prio) ||
                 ((node_rd.prio == best_q.prio) && (node_rd.order < best_q.order)));
    iter_n = (iter_q >= EXP_MAX) ? EXP_MAX : iter_q + CntW'(1);
    k_n    = k_q + CntW'(1);
    pdir   = dir_split(node_rd.parent);
    px5 = {1'b0, pc_q.x} + 5'd1 - {3'b0, pdir[5:4]};
    py5 = {1'b0, pc_q.y} + 5'd1 - {3'b0, pdir[3:2]};
    pz5 = {1'b0, pc_q.z} + 5'd1 - {3'b0, pdir[1:0]};
    raddr13 = path_cnt_q - CntW'(1) - CntW'(step_number_i);
  end

  // Memory port steering
  always_comb begin
    node_we = 1'b0; node_waddr = best_idx_q; node_wdata = best_q;
    node_re = 1'b0; node_raddr = sc_q[CellAw-1:0];
    clr_we = 1'b0; clr_waddr = sc_q[CellAw-1:0]; clr_wdata = '0;
    clr_re = 1'b0; clr_raddr = ncrd;
    path_we = 1'b0; path_waddr = k_q[CellAw-1:0]; path_wdata = pc_q;
    path_re = 1'b0; path_raddr = raddr13[CellAw-1:0];
    unique case (state_q)
      S_INIT: clr_we = 1'b1;
      S_IDLE: begin
        if (acc && (req_type_i == REQ_LOAD)) begin
          clr_we    = 1'b1;
          clr_waddr = {clamp_idx(cell_x_i, lx), clamp_idx(cell_y_i, ly),
                       clamp_idx(cell_z_i, lz)};
          clr_wdata = clearance_i;
        end
        path_re = acc && (req_type_i == REQ_READ);
      end
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = sc_q[CellAw-1:0];
        node_wdata = '{mark: MARK_FREE, default: '0};
      end
      S_SWR: begin
        node_we    = 1'b1;
        node_waddr = hc_q;
        node_wdata = '{mark: MARK_OPEN, cost: '0, prio: PrioW'(heur),
                       parent: NO_PARENT, order: '0};
      end
      S_SCAN: node_re = !sc_q[CellAw];
      S_SEL: begin
        node_we = any_q && (best_idx_q != goal_q);
        node_wdata.mark = MARK_CLOSED;
      end
      S_NB: begin
        node_re    = !nb_center && !nb_oob;
        node_raddr = ncrd;
        clr_re     = node_re;
      end
      S_NB_WR: begin
        node_we    = 1'b1;
        node_waddr = n_q;
        node_wdata = '{mark: MARK_OPEN, cost: t_q,
                       prio: PrioW'(t_q) + PrioW'(heur),
                       parent: DirW'(nbx_q) * DirW'(9) + DirW'(nby_q) * DirW'(3)
                               + DirW'(nbz_q),
                       order: ins_q};
      end
      S_PRD: begin
        node_re    = 1'b1;
        node_raddr = pc_q;
      end
      S_PWR: path_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      size_x_q <= SizeW'(16); size_y_q <= SizeW'(16); size_z_q <= SizeW'(16);
      tie_q <= TieW'(4096); cmin_q <= ClrW'(128);
      goal_q <= '0; hc_q <= '0; pc_q <= '0; best_q <= '0; best_idx_q <= '0;
      n_q <= '0; scan_a_q <= '0; any_q <= 1'b0; scan_v_q <= 1'b0;
      rd_path_q <= 1'b0; sc_q <= '0; iter_q <= '0; last_exp_q <= '0;
      path_cnt_q <= '0; k_q <= '0; nbx_q <= '0; nby_q <= '0; nbz_q <= '0;
      t_q <= '0; ins_q <= '0; st_q <= ST_DONE;
      out_valid_o <= 1'b0; status_o <= ST_DONE; path_length_o <= '0;
      path_x_o <= '0; path_y_o <= '0; path_z_o <= '0; expansions_o <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SIZE_X: size_x_q <= cfg_data_i[SizeW-1:0];
          CFG_SIZE_Y: size_y_q <= cfg_data_i[SizeW-1:0];
          CFG_SIZE_Z: size_z_q <= cfg_data_i[SizeW-1:0];
          CFG_TIE:    tie_q    <= cfg_data_i;
          CFG_CLRMIN: cmin_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i && (state_q != S_DONE)) out_valid_o <= 1'b0;

      unique case (state_q)
        S_INIT: begin
          sc_q <= sc_q + CntW'(1);
          if (sc_q == CntW'(NCells - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) begin
            rd_path_q <= 1'b0;
            st_q      <= ST_DONE;
            state_q   <= S_DONE;
            unique case (req_type_i)
              REQ_SEARCH: begin
                goal_q <= '{x: clamp_idx(goal_x_i, lx), y: clamp_idx(goal_y_i, ly),
                            z: clamp_idx(goal_z_i, lz)};
                hc_q   <= '{x: clamp_idx(start_x_i, lx), y: clamp_idx(start_y_i, ly),
                            z: clamp_idx(start_z_i, lz)};
                sc_q    <= '0;
                state_q <= S_CLR;
              end
              REQ_READ: begin
                if (CntW'(step_number_i) < path_cnt_q) rd_path_q <= 1'b1;
                else st_q <= ST_BEYOND;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          sc_q <= sc_q + CntW'(1);
          if (sc_q == CntW'(NCells - 1)) state_q <= S_SWR;
        end
        S_SWR: begin
          ins_q    <= OrdW'(1);
          iter_q   <= '0;
          sc_q     <= '0;
          any_q    <= 1'b0;
          scan_v_q <= 1'b0;
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          scan_v_q <= !sc_q[CellAw];
          scan_a_q <= sc_q[CellAw-1:0];
          if (!sc_q[CellAw]) sc_q <= sc_q + CntW'(1);
          if (scan_take) begin
            any_q      <= 1'b1;
            best_q     <= node_rd;
            best_idx_q <= scan_a_q;
          end
          if (sc_q[CellAw] && !scan_v_q) state_q <= S_SEL;
        end
        S_SEL: begin
          if (!any_q) begin
            path_cnt_q <= '0;
            last_exp_q <= iter_q;
            st_q       <= ST_NOPATH;
            state_q    <= S_DONE;
          end else if (best_idx_q == goal_q) begin
            last_exp_q <= iter_n;
            pc_q       <= goal_q;
            k_q        <= '0;
            state_q    <= S_PRD;
          end else begin
            iter_q  <= iter_n;
            nbx_q   <= '0; nby_q <= '0; nbz_q <= '0;
            state_q <= S_NB;
          end
        end
        S_NB: begin
          if (nb_center || nb_oob) begin
            nbx_q <= nbx_n; nby_q <= nby_n; nbz_q <= nbz_n;
            if (nb_last) begin
              sc_q <= '0; any_q <= 1'b0; scan_v_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end else begin
            hc_q    <= ncrd;
            n_q     <= ncrd;
            state_q <= S_NB_CHK;
          end
        end
        S_NB_CHK: begin
          t_q <= t_new;
          if (nb_skip) begin
            nbx_q <= nbx_n; nby_q <= nby_n; nbz_q <= nbz_n;
            if (nb_last) begin
              sc_q <= '0; any_q <= 1'b0; scan_v_q <= 1'b0;
              state_q <= S_SCAN;
            end else begin
              state_q <= S_NB;
            end
          end else begin
            state_q <= S_NB_HW;
          end
        end
        S_NB_HW: state_q <= S_NB_WR;
        S_NB_WR: begin
          ins_q <= ins_q + OrdW'(1);
          nbx_q <= nbx_n; nby_q <= nby_n; nbz_q <= nbz_n;
          if (nb_last) begin
            sc_q <= '0; any_q <= 1'b0; scan_v_q <= 1'b0;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_NB;
          end
        end
        S_PRD: state_q <= S_PWR;
        S_PWR: begin
          // stop at the start cell, a bad code, the length cap or the grid edge
          if (node_rd.parent == NO_PARENT || node_rd.parent > DIR_MAX ||
              k_n >= CntW'(NCells) || px5[4] || py5[4] || pz5[4]) begin
            path_cnt_q <= k_n;
            st_q       <= ST_FOUND;
            state_q    <= S_DONE;
          end else begin
            k_q     <= k_n;
            pc_q    <= '{x: px5[3:0], y: py5[3:0], z: pz5[3:0]};
            state_q <= S_PRD;
          end
        end
        S_DONE: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o   <= 1'b1;
            status_o      <= st_q;
            path_length_o <= path_cnt_q;
            expansions_o  <= last_exp_q;
            if (rd_path_q) begin
              path_x_o <= path_rdata[11:8];
              path_y_o <= path_rdata[7:4];
              path_z_o <= path_rdata[3:0];
            end else begin
              path_x_o <= '0; path_y_o <= '0; path_z_o <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FOUND) |-> (path_length_o != '0))
    else $error("found path reported with zero length");

  a_nopath_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOPATH) |-> (path_length_o == '0))
    else $error("no-path result with nonzero length");

  a_exp_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expansions_o <= EXP_MAX) && (path_length_o <= CntW'(NCells)))
    else $error("expansion count or path length above cap");

  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> in_stall_o)
    else $error("request taken during clearance clear");

endmodule

@@ src/gas_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module gas_ram #(
  parameter int Width = 8,
  parameter int Aw    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [1 << Aw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ src/gas_heur.sv @@
// Two-stage octile heuristic: distance, then tie-scale multiply with rounding.
module gas_heur import gas_pkg::*; (
  input  logic             clk_i,
  input  coord_t           cell_i,
  input  coord_t           goal_i,
  input  logic [TieW-1:0]  tie_i,
  output logic [HeurW-1:0] heur_o
);

  logic [CoordW-1:0] da, db, dc, a, b, c, t;
  logic [OctW-1:0]   oct_d, oct_q;
  logic [OctW+TieW-1:0] prod;

  always_comb begin
    t  = '0;
    da = (cell_i.x > goal_i.x) ? cell_i.x - goal_i.x : goal_i.x - cell_i.x;
    db = (cell_i.y > goal_i.y) ? cell_i.y - goal_i.y : goal_i.y - cell_i.y;
    dc = (cell_i.z > goal_i.z) ? cell_i.z - goal_i.z : goal_i.z - cell_i.z;
    a = da; b = db; c = dc;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    oct_d = OctW'(a) * OctW'(COST_SQ3) + OctW'(b - a) * OctW'(COST_SQ2)
          + OctW'(c - b) * OctW'(COST_ONE);
    prod = OctW'(oct_q) * (OctW + TieW)'(tie_i) + (OctW + TieW)'(2048);
  end

  always_ff @(posedge clk_i) begin
    oct_q  <= oct_d;
    heur_o <= prod[12 +: HeurW];
  end

endmodule

@@ bench/grid_a_star_path_search_tb.sv @@
// Self-checking bench for the grid A* search block: directed table, random phases.
module grid_a_star_path_search_tb;
  import gas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int LegalNoParent = 13;

  typedef struct {
    logic [1:0]      st;
    logic [CntW-1:0] plen;
    logic [3:0]      px;
    logic [3:0]      py;
    logic [3:0]      pz;
    logic [CntW-1:0] exps;
  } res_t;

  typedef struct {
    logic [1:0]       req;
    logic [3:0]       cx, cy, cz;
    logic [15:0]      clr;
    logic [3:0]       sx, sy, sz, gx, gy, gz;
    logic [StepW-1:0] step;
    bit               typed;
    res_t             res;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [CoordW-1:0] cell_x_i = '0, cell_y_i = '0, cell_z_i = '0;
  logic signed [ClrW-1:0] clearance_i = '0;
  logic [CoordW-1:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic [CoordW-1:0] goal_x_i = '0, goal_y_i = '0, goal_z_i = '0;
  logic [StepW-1:0] step_number_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [CntW-1:0] path_length_o;
  logic [CoordW-1:0] path_x_o, path_y_o, path_z_o;
  logic [CntW-1:0] expansions_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  grid_a_star_path_search DUT (.*);

  // predictor state
  int unsigned sz_x, sz_y, sz_z, tie_q12;
  int clr_floor;
  int clr_grid[NCells];
  logic [1:0] mark[NCells];
  longint unsigned g_cost[NCells], f_prio[NCells];
  int dir_code[NCells], ins_order[NCells];
  int unsigned ins_count, last_exp;
  coord_t path_cells[$];

  res_t pending_results[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_req = 0;

  function automatic int unsigned eff(int unsigned v);
    if (v == 0) return 1;
    return (v > DimSize) ? DimSize : v;
  endfunction

  function automatic int unsigned clampi(int unsigned v, int unsigned size);
    return (v >= size) ? size - 1 : v;
  endfunction

  function automatic int cell_id(int x, int y, int z);
    return (x * DimSize + y) * DimSize + z;
  endfunction

  function automatic longint unsigned octile_h(int x, int y, int z, int gx, int gy, int gz);
    int a, b, c, t;
    longint unsigned h;
    a = (x > gx) ? x - gx : gx - x;
    b = (y > gy) ? y - gy : gy - y;
    c = (z > gz) ? z - gz : gz - z;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    h = 64'(a * CostSq3I + (b - a) * CostSq2I + (c - b) * CostOneI);
    return (h * tie_q12 + 2048) >> 12;
  endfunction

  function automatic bit search_grid(int sx, int sy, int sz, int gx, int gy, int gz);
    int lx, ly, lz, s, goal, best, x, y, z, nx, ny, nz, moves, n, cx, cy, cz, d, k;
    int unsigned iter;
    bit found, any;
    longint unsigned stepc, t;
    lx = eff(sz_x); ly = eff(sz_y); lz = eff(sz_z);
    s = cell_id(sx, sy, sz);
    goal = cell_id(gx, gy, gz);
    iter = 0;
    found = 0;
    foreach (mark[i]) mark[i] = MARK_FREE;
    ins_count = 0;
    g_cost[s] = 0;
    f_prio[s] = octile_h(sx, sy, sz, gx, gy, gz);
    dir_code[s] = LegalNoParent;
    ins_order[s] = ins_count++;
    mark[s] = MARK_OPEN;
    while (1) begin
      any = 0;
      best = 0;
      for (int i = 0; i < NCells; i++) begin
        if (mark[i] != MARK_OPEN) continue;
        if (!any || f_prio[i] < f_prio[best] ||
            (f_prio[i] == f_prio[best] && ins_order[i] < ins_order[best])) begin
          best = i;
          any = 1;
        end
      end
      if (!any) break;
      iter++;
      if (best == goal) begin
        found = 1;
        break;
      end
      mark[best] = MARK_CLOSED;
      z = best % DimSize;
      y = (best / DimSize) % DimSize;
      x = best / (DimSize * DimSize);
      for (int dx = -1; dx <= 1; dx++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dz = -1; dz <= 1; dz++) begin
            nx = x + dx; ny = y + dy; nz = z + dz;
            moves = (dx != 0) + (dy != 0) + (dz != 0);
            if (moves == 0) continue;
            if (nx < 0 || ny < 0 || nz < 0 || nx >= lx || ny >= ly || nz >= lz) continue;
            n = cell_id(nx, ny, nz);
            if (clr_grid[n] < clr_floor) continue;
            if (mark[n] == MARK_CLOSED) continue;
            stepc = 64'((moves == 1) ? CostOneI : ((moves == 2) ? CostSq2I : CostSq3I));
            t = g_cost[best] + stepc;
            if (mark[n] == MARK_OPEN && t > g_cost[n]) continue;
            mark[n] = MARK_OPEN;
            dir_code[n] = (dx + 1) * 9 + (dy + 1) * 3 + (dz + 1);
            g_cost[n] = t;
            f_prio[n] = t + octile_h(nx, ny, nz, gx, gy, gz);
            ins_order[n] = ins_count++;
          end
    end
    last_exp = (iter > NCells) ? NCells : iter;
    path_cells.delete();
    if (found) begin
      cx = gx; cy = gy; cz = gz; k = 0;
      while (1) begin
        path_cells.push_front('{x: cx[3:0], y: cy[3:0], z: cz[3:0]});
        d = dir_code[cell_id(cx, cy, cz)];
        k++;
        if (d == LegalNoParent || d > 26 || k >= NCells) break;
        cx -= d / 9 - 1;
        cy -= (d / 3) % 3 - 1;
        cz -= d % 3 - 1;
        if (cx < 0 || cy < 0 || cz < 0 || cx >= DimSize || cy >= DimSize || cz >= DimSize)
          break;
      end
    end
    return found;
  endfunction

  function automatic res_t serve_request(req_row_t r);
    res_t e;
    int unsigned lx, ly, lz;
    lx = eff(sz_x); ly = eff(sz_y); lz = eff(sz_z);
    e = '{st: ST_DONE, plen: '0, px: '0, py: '0, pz: '0, exps: '0};
    case (r.req)
      REQ_LOAD: begin
        clr_grid[cell_id(clampi(r.cx, lx), clampi(r.cy, ly), clampi(r.cz, lz))] =
          int'($signed(r.clr));
      end
      REQ_SEARCH: begin
        e.st = search_grid(clampi(r.sx, lx), clampi(r.sy, ly), clampi(r.sz, lz),
                           clampi(r.gx, lx), clampi(r.gy, ly), clampi(r.gz, lz))
               ? ST_FOUND : ST_NOPATH;
      end
      REQ_READ: begin
        if (r.step < path_cells.size()) begin
          e.px = path_cells[r.step].x;
          e.py = path_cells[r.step].y;
          e.pz = path_cells[r.step].z;
        end else begin
          e.st = ST_BEYOND;
        end
      end
      default: ;
    endcase
    e.plen = CntW'(path_cells.size());
    e.exps = CntW'(last_exp);
    return e;
  endfunction

  function automatic req_row_t blank_row(logic [1:0] req);
    req_row_t r;
    r = '{default: '0};
    r.req = req;
    return r;
  endfunction

  function automatic req_row_t load_row(int x, int y, int z, int c);
    req_row_t r;
    r = blank_row(REQ_LOAD);
    r.cx = 4'(x); r.cy = 4'(y); r.cz = 4'(z); r.clr = 16'(c);
    return r;
  endfunction

  function automatic req_row_t search_row(int sx, int sy, int sz, int gx, int gy, int gz);
    req_row_t r;
    r = blank_row(REQ_SEARCH);
    r.sx = 4'(sx); r.sy = 4'(sy); r.sz = 4'(sz);
    r.gx = 4'(gx); r.gy = 4'(gy); r.gz = 4'(gz);
    return r;
  endfunction

  function automatic req_row_t read_row(int step);
    req_row_t r;
    r = blank_row(REQ_READ);
    r.step = StepW'(step);
    return r;
  endfunction

  function automatic req_row_t known(req_row_t r, logic [1:0] st, int plen, int exps);
    r.typed = 1;
    r.res = '{st: st, plen: CntW'(plen), px: '0, py: '0, pz: '0, exps: CntW'(exps)};
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic offer(req_row_t r);
    res_t e;
    req_type_i = r.req;
    cell_x_i = r.cx; cell_y_i = r.cy; cell_z_i = r.cz;
    clearance_i = r.clr;
    start_x_i = r.sx; start_y_i = r.sy; start_z_i = r.sz;
    goal_x_i = r.gx; goal_y_i = r.gy; goal_z_i = r.gz;
    step_number_i = r.step;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    e = serve_request(r);
    pending_results = {pending_results, (r.typed ? r.res : e)};
    @(negedge clk_i);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 14) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    cfg_index_i = idx;
    cfg_data_i = val[15:0];
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SIZE_X: sz_x = val & 31;
      CFG_SIZE_Y: sz_y = val & 31;
      CFG_SIZE_Z: sz_z = val & 31;
      CFG_TIE:    tie_q12 = val & 16'hFFFF;
      CFG_CLRMIN: clr_floor = $signed(val[15:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_all(int x, int y, int z, int tie, int cmin);
    write_reg(CFG_SIZE_X, x);
    write_reg(CFG_SIZE_Y, y);
    write_reg(CFG_SIZE_Z, z);
    write_reg(CFG_TIE, tie);
    write_reg(CFG_CLRMIN, cmin);
  endtask

  function automatic req_row_t random_row();
    req_row_t r;
    int pick, c;
    pick = $urandom_range(0, 99);
    r = blank_row(REQ_LOAD);
    if (pick < 50) begin
      if ($urandom_range(0, 4) == 0) begin
        r.cx = 4'($urandom); r.cy = 4'($urandom); r.cz = 4'($urandom);
      end else begin
        r.cx = 4'($urandom_range(0, eff(sz_x) - 1));
        r.cy = 4'($urandom_range(0, eff(sz_y) - 1));
        r.cz = 4'($urandom_range(0, eff(sz_z) - 1));
      end
      if ($urandom_range(0, 3) == 0) begin
        r.clr = 16'($urandom);
      end else begin
        c = clr_floor + int'($urandom_range(0, 300)) - 40;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        r.clr = 16'(c);
      end
    end else if (pick < 60) begin
      r = search_row($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
    end else if (pick < 93) begin
      r = read_row(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, path_cells.size()));
    end else begin
      r = blank_row(REQ_SPARE);
      r.cx = 4'($urandom); r.clr = 16'($urandom); r.sx = 4'($urandom);
      r.step = StepW'($urandom);
    end
    return r;
  endfunction

  // response side: random stall plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = (!quiet && $urandom_range(0, 99) < 14);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d len=%0d", $time, status_o, path_length_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.st || path_length_o !== e.plen || path_x_o !== e.px ||
            path_y_o !== e.py || path_z_o !== e.pz || expansions_o !== e.exps) begin
          $display("%0t: mismatch expected st=%0d len=%0d xyz=%0d,%0d,%0d exp=%0d",
                   $time, e.st, e.plen, e.px, e.py, e.pz, e.exps);
          $display("%0t:          actual st=%0d len=%0d xyz=%0d,%0d,%0d exp=%0d",
                   $time, status_o, path_length_o, path_x_o, path_y_o, path_z_o,
                   expansions_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #2s;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    req_row_t rows[$];
    sz_x = 16; sz_y = 16; sz_z = 16; tie_q12 = 4096; clr_floor = 128;
    foreach (clr_grid[i]) clr_grid[i] = 0;
    ins_count = 0; last_exp = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config: every cell blocked
    rows = {rows, known(read_row(0), ST_BEYOND, 0, 0)};
    rows = {rows, known(blank_row(REQ_SPARE), ST_DONE, 0, 0)};
    rows = {rows, known(search_row(0, 0, 0, 0, 0, 0), ST_FOUND, 1, 1)};
    rows = {rows, known(read_row(0), ST_DONE, 1, 1)};
    rows = {rows, known(read_row(1), ST_BEYOND, 1, 1)};
    rows = {rows, load_row(15, 15, 15, 32767)};
    rows = {rows, load_row(0, 0, 15, -32768)};
    rows = {rows, known(search_row(15, 15, 15, 0, 0, 0), ST_NOPATH, 0, 1)};
    rows = {rows, known(read_row(4095), ST_BEYOND, 0, 1)};
    foreach (rows[i]) offer(rows[i]);
    drain();

    set_all(3, 3, 2, 0, 16'h8000);
    rows.delete();
    rows = {rows, search_row(0, 0, 0, 2, 2, 1)};
    rows = {rows, read_row(0)};
    rows = {rows, read_row(2)};
    rows = {rows, read_row(4095)};
    rows = {rows, search_row(15, 15, 15, 0, 0, 0)};
    rows = {rows, read_row(1)};
    foreach (rows[i]) offer(rows[i]);
    drain();

    // only cells loaded at the top value pass
    set_all(3, 3, 2, 65535, 32767);
    rows.delete();
    rows = {rows, load_row(1, 1, 0, 32767)};
    rows = {rows, load_row(2, 2, 1, 32767)};
    rows = {rows, search_row(0, 0, 0, 2, 2, 1)};
    rows = {rows, read_row(1)};
    rows = {rows, read_row(2)};
    rows = {rows, search_row(15, 15, 15, 15, 15, 15)};
    foreach (rows[i]) offer(rows[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) set_all(0, 31, 2, 4096, 0);
      else set_all($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                   (ph == 4) ? 65535 : $urandom_range(0, 8192), $urandom_range(0, 400) - 200);
      quiet = (ph == 3);
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 20; n++) offer(random_row());
      drain();
    end
    quiet = 0;
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
